@@ hw/rtl/psvd_pkg.sv @@
// Shared types and constants for the variable time step PID controller.
// Used by the multiplier, the divider and the top level; depends on nothing.
`default_nettype none

package psvd_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W   = 32;
    localparam int ERR_W    = 33;
    localparam int DIFF_W   = 34;
    localparam int INT_W    = 48;
    localparam int MUL_A_W  = 48;
    localparam int MUL_B_W  = 33;
    localparam int DIGIT_W  = 16;
    localparam int MUL_STEPS = MUL_A_W / DIGIT_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 2'd3;

    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] num;
        logic [DATA_W-1:0] den;
    } t_div_req;

endpackage

`default_nettype wire

@@ hw/rtl/pid_step_variable_dt.sv @@
// Positional PID controller step with a variable time step, fixed point.
// Depends on psvd_pkg, psvd_mul and psvd_div.
//
// Usage: the slave stream carries one sample per transfer: measured value
// in tdata[31:0] and time step in tdata[63:32]. The master stream returns
// one result per sample: drive in tdata[31:0], the clipped flag in tuser.
// Setpoint and gains are written through the plain write port
// (index 0 setpoint, 1 proportional, 2 integral, 3 derivative gain) while
// the block is idle.
// The restoring divider of the derivative term produces one quotient bit
// per cycle over 34 + FRAC_BITS bits. The four products share one
// multiplier; three of them overlap the division. One sample is in work
// at a time, so a new sample is accepted only once the previous result
// has been loaded into the output register. Reset clears the integral and
// the stored error, sets the setpoint to zero and all gains to 1.0. When
// the receiver stalls, the result is held in the output register; a new
// sample may be accepted, and its result waits until the held one has
// been transferred.
`default_nettype none

module pid_step_variable_dt
    import psvd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [2*DATA_W-1:0]   s_axis_tdata,  // measured, time_step
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [DATA_W-1:0]          m_axis_tdata,  // drive
    output logic                       m_axis_tuser,  // clipped
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [DATA_W-1:0]     i_cfg_data
);

    localparam int DIV_W = DIFF_W + FRAC_BITS;
    localparam logic [DATA_W-1:0] GAIN_ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic [63:0] DER_POS_MAX = 64'({1'b0, {(INT_W-1){1'b1}}});
    localparam logic [63:0] DER_NEG_MAX = 64'({1'b1, {(INT_W-1){1'b0}}});

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_INC, S_P, S_I, S_DWAIT, S_D, S_OUT
    } t_state;

    t_state                    r_state;
    logic signed [DATA_W-1:0]  r_setpoint, r_gain_p, r_gain_i, r_gain_d;
    logic [DATA_W-1:0]         r_dt;
    logic signed [ERR_W-1:0]   r_err, r_last_err;
    logic signed [INT_W-1:0]   r_int;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_clip, r_mul_neg, r_diff_neg;
    t_mul_req                  r_mul_req;
    t_div_req                  r_div_req;
    logic                      r_out_valid, r_out_clip;
    logic [DATA_W-1:0]         r_out_drive;

    logic                      mul_done;
    logic [PROD_W-1:0]         mul_prod;
    logic                      div_busy;
    logic [DIV_W-1:0]          div_quo;

    logic signed [ERR_W-1:0]   n_err;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [ERR_W-1:0]          err_mag;
    logic [INT_W-1:0]          int_mag;
    logic [DATA_W-1:0]         gp_mag, gi_mag, gd_mag;
    logic signed [ACC_W-1:0]   term, acc_sum;
    logic [63:0]               inc_mag;
    logic signed [INT_W+17:0]  int_sum;
    logic                      int_fit;
    logic [INT_W-1:0]          int_next;
    logic [63:0]               q_ext;
    logic [INT_W-1:0]          der_mag;
    logic signed [ACC_W-1:0]   acc_sh;
    logic                      drv_fit;
    logic [DATA_W-1:0]         drv;
    logic                      mul_issue;
    logic                      out_load;

    psvd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    psvd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_err    = {r_setpoint[DATA_W-1], r_setpoint}
                 - {s_axis_tdata[DATA_W-1], s_axis_tdata[DATA_W-1:0]};
        diff     = {r_err[ERR_W-1], r_err} - {r_last_err[ERR_W-1], r_last_err};
        diff_mag = diff[DIFF_W-1] ? -diff : diff;
        err_mag  = r_err[ERR_W-1] ? -r_err : r_err;
        int_mag  = r_int[INT_W-1] ? -r_int : r_int;
        gp_mag   = r_gain_p[DATA_W-1] ? -r_gain_p : r_gain_p;
        gi_mag   = r_gain_i[DATA_W-1] ? -r_gain_i : r_gain_i;
        gd_mag   = r_gain_d[DATA_W-1] ? -r_gain_d : r_gain_d;

        term     = r_mul_neg ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
        acc_sum  = r_acc + term;

        inc_mag  = mul_prod[63:0] >> FRAC_BITS;
        int_sum  = {{18{r_int[INT_W-1]}}, r_int}
                 + (r_err[ERR_W-1] ? -$signed({2'b00, inc_mag})
                                   : $signed({2'b00, inc_mag}));
        int_fit  = (&int_sum[INT_W+17:INT_W-1]) || !(|int_sum[INT_W+17:INT_W-1]);
        int_next = int_fit ? int_sum[INT_W-1:0]
                           : (int_sum[INT_W+17] ? INT_MIN : INT_MAX);

        q_ext    = 64'(div_quo);
        if (r_diff_neg) begin
            der_mag = (q_ext > DER_NEG_MAX) ? DER_NEG_MAX[INT_W-1:0] : q_ext[INT_W-1:0];
        end else begin
            der_mag = (q_ext > DER_POS_MAX) ? DER_POS_MAX[INT_W-1:0] : q_ext[INT_W-1:0];
        end

        acc_sh   = r_acc >>> FRAC_BITS;
        drv_fit  = (&acc_sh[ACC_W-1:DATA_W-1]) || !(|acc_sh[ACC_W-1:DATA_W-1]);
        drv      = drv_fit ? acc_sh[DATA_W-1:0]
                           : (acc_sh[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                              : {1'b0, {(DATA_W-1){1'b1}}});

        unique case (r_state)
            S_START:    mul_issue = 1'b1;
            S_INC, S_P: mul_issue = mul_done;
            S_DWAIT:    mul_issue = !div_busy;
            default:    mul_issue = 1'b0;
        endcase
        out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_setpoint      <= '0;
            r_gain_p        <= GAIN_ONE;
            r_gain_i        <= GAIN_ONE;
            r_gain_d        <= GAIN_ONE;
            r_int           <= '0;
            r_last_err      <= '0;
            r_out_valid     <= 1'b0;
            r_mul_req.start <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_mul_req.start <= mul_issue;
            r_div_req.start <= (r_state == S_START);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SETPOINT: r_setpoint <= i_cfg_data;
                    REG_GAIN_P:   r_gain_p   <= i_cfg_data;
                    REG_GAIN_I:   r_gain_i   <= i_cfg_data;
                    REG_GAIN_D:   r_gain_d   <= i_cfg_data;
                    default:      ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_err   <= n_err;
                        r_dt    <= s_axis_tdata[2*DATA_W-1:DATA_W];
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_div_req.num <= diff_mag;
                    r_div_req.den <= r_dt;
                    r_diff_neg    <= diff[DIFF_W-1];
                    r_mul_req.a   <= MUL_A_W'(err_mag);
                    r_mul_req.b   <= MUL_B_W'(r_dt);
                    r_last_err    <= r_err;
                    r_state       <= S_INC;
                end
                S_INC: begin
                    if (mul_done) begin
                        r_int       <= int_next;
                        r_clip      <= !int_fit;
                        r_acc       <= '0;
                        r_mul_req.a <= MUL_A_W'(gp_mag);
                        r_mul_req.b <= err_mag;
                        r_mul_neg   <= r_gain_p[DATA_W-1] ^ r_err[ERR_W-1];
                        r_state     <= S_P;
                    end
                end
                S_P: begin
                    if (mul_done) begin
                        r_acc       <= acc_sum;
                        r_mul_req.a <= int_mag;
                        r_mul_req.b <= MUL_B_W'(gi_mag);
                        r_mul_neg   <= r_gain_i[DATA_W-1] ^ r_int[INT_W-1];
                        r_state     <= S_I;
                    end
                end
                S_I: begin
                    if (mul_done) begin
                        r_acc   <= acc_sum;
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (!div_busy) begin
                        r_mul_req.a <= der_mag;
                        r_mul_req.b <= MUL_B_W'(gd_mag);
                        r_mul_neg   <= r_gain_d[DATA_W-1] ^ r_diff_neg;
                        r_state     <= S_D;
                    end
                end
                S_D: begin
                    if (mul_done) begin
                        r_acc   <= acc_sum;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_drive <= drv;
                        r_out_clip  <= r_clip || !drv_fit;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_drive;
    assign m_axis_tuser  = r_out_clip;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_START))
        else $error("accepted sample did not start a step");

    a_mul_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state != S_IDLE && r_state != S_START))
        else $error("multiplier finished outside a step");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_req.start |-> !div_busy)
        else $error("divider started while busy");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !m_axis_tready) |=> (r_state == S_OUT))
        else $error("held result was overwritten");

endmodule

`default_nettype wire

@@ hw/rtl/psvd_mul.sv @@
// Shared unsigned multiplier: 48 x 33 bits, one 16-bit digit of the first
// operand per cycle. Depends on psvd_pkg.
`default_nettype none

module psvd_mul
    import psvd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mul_req          i_req,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_prod
);

    localparam int CNT_W = $clog2(MUL_STEPS + 1);

    logic [MUL_A_W-1:0]         r_a;
    logic [MUL_B_W-1:0]         r_b;
    logic [PROD_W-1:0]          r_acc;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;
    logic [DIGIT_W+MUL_B_W-1:0] pp;

    assign pp = r_a[MUL_A_W-1 -: DIGIT_W] * r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a   <= i_req.a;
                r_b   <= i_req.b;
                r_acc <= '0;
                r_cnt <= CNT_W'(MUL_STEPS);
            end else if (r_cnt != '0) begin
                r_acc <= {r_acc[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(pp);
                r_a   <= {r_a[MUL_A_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ hw/rtl/psvd_div.sv @@
// Restoring divider, one quotient bit per cycle, for the derivative term.
// The dividend is the error difference magnitude shifted up by FRAC_BITS.
// Depends on psvd_pkg.
`default_nettype none

module psvd_div
    import psvd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_div_req                    i_req,
    output logic                             o_busy,
    output logic [DIFF_W+FRAC_BITS-1:0]      o_quo
);

    localparam int DIV_W = DIFF_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_num;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_num[DIV_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            if (i_req.start) begin
                r_num <= {i_req.num, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_den <= (i_req.den == '0) ? DATA_W'(1) : i_req.den;
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                r_num <= {r_num[DIV_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_num;

endmodule

`default_nettype wire

@@ sim/pid_step_variable_dt_tb.sv @@
// Testbench for the variable time step PID controller: directed and random samples
// with random idling on both streams, results checked against a fixed point predictor.
// Depends on psvd_pkg and the pid_step_variable_dt RTL.
module pid_step_variable_dt_tb
    import psvd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_PHASES = 10;
    localparam int SAMPLES_PER_PHASE = 65;

    localparam logic signed [127:0] SUM_HI = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [127:0] SUM_LO = -128'sh8000_0000_0000;
    localparam logic signed [127:0] DRV_HI = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] DRV_LO = -128'sh8000_0000;
    localparam logic [127:0] DER_CAP = 128'h8000_0000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              clipped;
    } t_drive;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [2*DATA_W-1:0] s_axis_tdata = '0;  // measured, time_step
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;         // drive
    logic m_axis_tuser;                      // clipped
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DATA_W-1:0] i_cfg_data = '0;

    // Controller state as the predictor sees it.
    logic signed [31:0] setpoint_q = 32'sd0;
    logic signed [31:0] kp_q = 32'sd1 <<< FRAC;
    logic signed [31:0] ki_q = 32'sd1 <<< FRAC;
    logic signed [31:0] kd_q = 32'sd1 <<< FRAC;
    logic signed [47:0] integral_q = 48'sd0;
    logic signed [32:0] prev_error_q = 33'sd0;

    logic [2*DATA_W-1:0] pending_samples[$];
    t_drive expected_drives[$];

    bit idle_on = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    int mismatches = 0;
    int n_samples = 0;
    int n_checked = 0;
    int n_clipped = 0;
    int n_settings = 0;

    pid_step_variable_dt dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_drive pid_step_predict(input logic [31:0] meas_bits,
                                                input logic [31:0] dt);
        logic signed [127:0] meas, err, err_mag, dt_s, inc, isum;
        logic signed [127:0] diff, diff_mag, der, kp, ki, kd, acc, scaled;
        logic [127:0] quo, dvsr;
        t_drive r;
        r.clipped = 1'b0;
        meas = $signed(meas_bits);
        err = setpoint_q;
        err = err - meas;
        err_mag = (err < 0) ? -err : err;
        dt_s = {96'd0, dt};
        inc = (err_mag * dt_s) >>> FRAC;
        if (err < 0) begin
            inc = -inc;
        end
        isum = integral_q;
        isum = isum + inc;
        if (isum > SUM_HI) begin
            isum = SUM_HI;
            r.clipped = 1'b1;
        end else if (isum < SUM_LO) begin
            isum = SUM_LO;
            r.clipped = 1'b1;
        end
        diff = prev_error_q;
        diff = err - diff;
        diff_mag = (diff < 0) ? -diff : diff;
        dvsr = (dt == 32'd0) ? 128'd1 : {96'd0, dt};
        quo = diff_mag;
        quo = (quo << FRAC) / dvsr;
        if (quo > DER_CAP) begin
            quo = DER_CAP;
        end
        der = quo;
        if (diff < 0) begin
            der = -der;
        end
        if (der > SUM_HI) begin
            der = SUM_HI;
        end
        kp = kp_q;
        ki = ki_q;
        kd = kd_q;
        acc = kp * err + ki * isum + kd * der;
        scaled = acc >>> FRAC;
        if (scaled > DRV_HI) begin
            scaled = DRV_HI;
            r.clipped = 1'b1;
        end else if (scaled < DRV_LO) begin
            scaled = DRV_LO;
            r.clipped = 1'b1;
        end
        r.drive = scaled[31:0];
        integral_q = isum[47:0];
        prev_error_q = err[32:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 4);
        end
        if (roll < 97) begin
            return $urandom_range(5, 30);
        end
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [31:0] pick_gain();
        logic [31:0] g;
        g = $urandom_range(0, 32'h0004_0000);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3, 4: return $urandom();
            default: return $urandom_range(0, 1) ? -g : g;
        endcase
    endfunction

    function automatic logic [31:0] pick_setpoint();
        logic [31:0] s;
        s = $urandom_range(0, 32'h0080_0000);
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return s - 32'h0040_0000;
        endcase
    endfunction

    function automatic logic [63:0] pick_sample();
        logic [31:0] meas, dt;
        case ($urandom_range(0, 9))
            0, 1: meas = $urandom();
            2: meas = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: meas = setpoint_q + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        endcase
        case ($urandom_range(0, 9))
            0, 1: dt = $urandom();
            2: dt = $urandom_range(0, 255);
            3: dt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: dt = $urandom_range(32'h0000_0100, 32'h0004_0000);
        endcase
        return {dt, meas};
    endfunction

    task automatic queue_sample(input logic [31:0] meas, input logic [31:0] dt);
        pending_samples.push_back({dt, meas});
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SETPOINT: setpoint_q = val;
            REG_GAIN_P: kp_q = val;
            REG_GAIN_I: ki_q = val;
            REG_GAIN_D: kd_q = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] sp, input logic [31:0] kp,
                                 input logic [31:0] ki, input logic [31:0] kd);
        write_register(REG_SETPOINT, sp);
        write_register(REG_GAIN_P, kp);
        write_register(REG_GAIN_I, ki);
        write_register(REG_GAIN_D, kd);
        n_settings++;
    endtask

    task automatic wait_until_drained();
        do begin
            @(negedge i_clk);
        end while (pending_samples.size() != 0 || s_axis_tvalid
                   || expected_drives.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sender: each sample waits out a random gap after the previous transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_drives.push_back(pid_step_predict(s_axis_tdata[31:0],
                                                           s_axis_tdata[63:32]));
                n_samples++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_samples.size() != 0) begin
                    s_axis_tdata <= pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compares every result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_drive want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_drives.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("Unexpected result: drive %h clipped %b",
                                 m_axis_tdata, m_axis_tuser);
                    end
                    mismatches++;
                end else begin
                    want = expected_drives.pop_front();
                    n_checked++;
                    if (m_axis_tuser) begin
                        n_clipped++;
                    end
                    if (m_axis_tdata !== want.drive || m_axis_tuser !== want.clipped) begin
                        if (mismatches < 10) begin
                            $display("Mismatch on result %0d: drive %h clipped %b,",
                                     n_checked, m_axis_tdata, m_axis_tuser,
                                     " expected %h %b", want.drive, want.clipped);
                        end
                        mismatches++;
                    end
                end
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left <= pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_drives.size());
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of setpoint and gains, extremes of both fields, zero time step.
        idle_on = 1'b1;
        queue_sample(32'h0000_0000, 32'h0001_0000);
        queue_sample(32'h7FFF_FFFF, 32'h0000_0001);
        queue_sample(32'h8000_0000, 32'hFFFF_FFFF);
        queue_sample(32'h0001_0000, 32'h0000_0000);
        queue_sample(32'hFFFF_0000, 32'h0000_8000);
        queue_sample(32'h0000_0000, 32'hFFFF_FFFF);
        queue_sample(32'h1234_5678, 32'h0002_0000);
        queue_sample(32'h0000_0000, 32'h0000_0001);
        wait_until_drained();

        // Drive the integral into positive saturation with extreme gains.
        idle_on = 1'b0;
        load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        repeat (3) queue_sample(32'h8000_0000, 32'hFFFF_FFFF);
        queue_sample(32'h7FFF_FFFF, 32'h0000_0000);
        queue_sample(32'h8000_0000, 32'h0000_0001);
        queue_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        wait_until_drained();

        // And into negative saturation.
        idle_on = 1'b1;
        load_settings(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000);
        repeat (4) queue_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_sample(32'h8000_0000, 32'h0000_0000);
        queue_sample(32'h0000_0000, 32'h0001_0000);
        wait_until_drained();

        load_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_sample(32'h5555_AAAA, 32'hAAAA_5555);
        queue_sample(32'hAAAA_5555, 32'h5555_AAAA);
        wait_until_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = ($urandom_range(0, 4) != 0);
            load_settings(pick_setpoint(), pick_gain(), pick_gain(), pick_gain());
            repeat (SAMPLES_PER_PHASE) pending_samples.push_back(pick_sample());
            wait_until_drained();
        end

        $display("Covered %0d samples under %0d register settings;",
                 n_samples, n_settings + 1,
                 " %0d results checked, %0d clipped.", n_checked, n_clipped);
        $display("Mismatches: %0d, predictions left over: %0d",
                 mismatches, expected_drives.size());
        if (mismatches == 0 && expected_drives.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
